// File: sv/utf8_to_cp1251_stream_core_defines.svh
// Assertion macros used by the checker file.
`ifndef UTF8_TO_CP1251_STREAM_CORE_DEFINES_SVH
`define UTF8_TO_CP1251_STREAM_CORE_DEFINES_SVH

// Check on every clock edge outside reset.
`define U2C_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every clock edge, reset included.
`define U2C_ASSERT_RST(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/u2c_pkg.sv
package u2c_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_SECOND  = 2'd1,
      MODE_SKIP    = 2'd2,
      MODE_DISCARD = 2'd3
   } mode_type;

   localparam logic [1:0] ST_CHAR = 2'd0;
   localparam logic [1:0] ST_END  = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   localparam logic [7:0] QMARK      = 8'h3F;
   localparam logic [7:0] TABLE_BASE = 8'h82;
   localparam int         TABLE_LEN  = 62;

   // Unicode code point of each Windows-1251 byte 0x82..0xBF
   localparam logic [15:0] CP_OF_BYTE [TABLE_LEN] = '{
      16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021, 16'h20AC, 16'h2030,
      16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F, 16'h0452, 16'h2018,
      16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h20C0, 16'h2122,
      16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F, 16'h00A0, 16'h040E,
      16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7, 16'h0401, 16'h00A9,
      16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407, 16'h00B0, 16'h00B1,
      16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7, 16'h0451, 16'h2116,
      16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
   };

   function automatic logic [7:0] map_code_point(input logic [10:0] cp);
      logic [7:0] res;
      res = QMARK;
      // descending scan so the lowest matching index wins
      for (int k = TABLE_LEN - 1; k >= 0; k--) begin
         if (CP_OF_BYTE[k] == {5'd0, cp}) begin
            res = TABLE_BASE + 8'(k);
         end
      end
      if (cp >= 11'h402 && cp <= 11'h403) begin
         res = 8'(cp - 11'h382);
      end
      if (cp >= 11'h080 && cp <= 11'h0FF) begin
         res = cp[7:0];
      end
      if (cp >= 11'h410 && cp <= 11'h44F) begin
         res = 8'(cp - 11'h350);
      end
      return res;
   endfunction

endpackage

// File: sv/u2c_if.sv
interface u2c_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface u2c_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] status;

   modport source (output valid, output out_byte, output status, input ready);
   modport sink   (input valid, input out_byte, input status, output ready);
endinterface

// File: sv/utf8_to_cp1251_stream_core.sv
// Channel   Direction  Payload
// req_if    in         in_byte  (UTF-8 byte, 0 ends the string)
// rsp_if    out        out_byte, status (0 char, 1 end, 2 malformed)
//
// One byte per cycle sustained while rsp_if is not stalled; the result of a byte
// is valid on rsp_if once it has passed the input register and been decoded
// into the result register. The 62-entry reverse match sits between the two
// registers and sets the clock period, not the latency.
// reset clears the decode mode and both valid flags synchronously.
// A stall on rsp_if holds both registers; req_if stays ready while either
// register is empty or the result register is being taken.
module utf8_to_cp1251_stream_core
   import u2c_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   u2c_req_if.sink   req_if,
   u2c_rsp_if.source rsp_if
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   mode_type   mode_ff, mode_in;
   logic [4:0] lead_ff, lead_in;
   logic [1:0] skip_ff, skip_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic [1:0] rsp_status_ff;

   logic       out_free;
   logic       s1_go;
   logic       emit;
   logic [7:0] emit_byte;
   logic [1:0] emit_status;
   logic [1:0] skip_dec;
   logic [7:0] mapped;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign s1_go        = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || out_free;
   assign skip_dec     = skip_ff - 2'd1;
   assign mapped       = map_code_point({lead_ff, s1_byte_ff[5:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         lead_ff      <= '0;
         skip_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         lead_ff      <= lead_in;
         skip_ff      <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_byte_ff <= req_if.in_byte;
      end
      if (s1_go && emit) begin
         rsp_byte_ff   <= emit_byte;
         rsp_status_ff <= emit_status;
      end
   end

   always_comb begin
      emit        = 1'b0;
      emit_byte   = 8'd0;
      emit_status = ST_CHAR;
      mode_in     = mode_ff;
      lead_in     = lead_ff;
      skip_in     = skip_ff;
      case (mode_ff)
         MODE_IDLE: begin
            emit = 1'b1;
            if (s1_byte_ff == 8'd0) begin
               emit_status = ST_END;
            end else if (!s1_byte_ff[7]) begin
               emit_byte = s1_byte_ff;
            end else if (s1_byte_ff[7:5] == 3'b110) begin
               emit    = 1'b0;
               lead_in = s1_byte_ff[4:0];
               mode_in = MODE_SECOND;
            end else if (s1_byte_ff[7:4] == 4'b1110) begin
               emit    = 1'b0;
               skip_in = 2'd2;
               mode_in = MODE_SKIP;
            end else if (s1_byte_ff[7:3] == 5'b11110) begin
               emit    = 1'b0;
               skip_in = 2'd3;
               mode_in = MODE_SKIP;
            end else begin
               emit_status = ST_BAD;
               mode_in     = MODE_DISCARD;
            end
         end
         MODE_SECOND: begin
            emit    = 1'b1;
            mode_in = MODE_IDLE;
            if (s1_byte_ff == 8'd0) begin
               emit_status = ST_BAD;
            end else begin
               emit_byte = mapped;
            end
         end
         MODE_SKIP: begin
            if (s1_byte_ff == 8'd0) begin
               emit        = 1'b1;
               emit_status = ST_BAD;
               mode_in     = MODE_IDLE;
               skip_in     = 2'd0;
            end else begin
               skip_in = skip_dec;
               if (skip_dec == 2'd0) begin
                  emit      = 1'b1;
                  emit_byte = QMARK;
                  mode_in   = MODE_IDLE;
               end
            end
         end
         default: begin
            // drop bytes up to the end of the rejected string
            if (s1_byte_ff == 8'd0) begin
               mode_in = MODE_IDLE;
            end
         end
      endcase
      // hold state unless the staged byte advances
      if (!s1_go) begin
         emit    = 1'b0;
         mode_in = mode_ff;
         lead_in = lead_ff;
         skip_in = skip_ff;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_if.valid && req_if.ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.out_byte = rsp_byte_ff;
   assign rsp_if.status   = rsp_status_ff;

endmodule

// File: sv/u2c_checker.sv
`include "utf8_to_cp1251_stream_core_defines.svh"

module u2c_checker
   import u2c_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic [7:0] rsp_byte,
   input logic [1:0] rsp_status
);

   logic flag_beat;
   logic char_beat;

   assign flag_beat = rsp_valid && rsp_status != ST_CHAR;
   assign char_beat = rsp_valid && rsp_status == ST_CHAR;

   `U2C_ASSERT_RST(a_reset_clears, reset |=> !rsp_valid, "result valid after reset")
   `U2C_ASSERT(a_status_legal, rsp_valid |-> rsp_status <= ST_BAD, "illegal status")
   `U2C_ASSERT(a_flag_zero_byte, flag_beat |-> rsp_byte == 8'd0, "flag transaction with byte")
   `U2C_ASSERT(a_char_nonzero, char_beat |-> rsp_byte != 8'd0, "zero character byte")

endmodule

bind utf8_to_cp1251_stream_core u2c_checker chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_byte   (rsp_if.out_byte),
   .rsp_status (rsp_if.status)
);

// File: tb/tb_utf8_to_cp1251_stream_core.sv
module tb_utf8_to_cp1251_stream_core
   import u2c_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int RANDOM_BYTES = 1600;
   localparam logic [7:0] REPLACEMENT = 8'h3F;

   // Unicode code points of Windows-1251 bytes 0x82 through 0xBF
   localparam logic [15:0] CP1251_HIGH_CP [62] = '{
      16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021, 16'h20AC, 16'h2030,
      16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F, 16'h0452, 16'h2018,
      16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h20C0, 16'h2122,
      16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F, 16'h00A0, 16'h040E,
      16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7, 16'h0401, 16'h00A9,
      16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407, 16'h00B0, 16'h00B1,
      16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7, 16'h0451, 16'h2116,
      16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
   };

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] status;
   } cp1251_result_type;

   logic clock;
   logic reset;

   u2c_req_if req_ch();
   u2c_rsp_if rsp_ch();

   utf8_to_cp1251_stream_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // decoder state mirrored by the testbench
   mode_type          dec_mode;
   logic [4:0]        dec_lead;
   logic [1:0]        dec_skip;
   int unsigned       decoded_count;
   cp1251_result_type cp1251_pending[$];
   cp1251_result_type cp1251_head;

   int unsigned cycle_count;
   int          fail_count;
   bit          send_burst;
   bit          recv_burst;
   int          recv_stall;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [7:0] to_cp1251(input logic [10:0] cp);
      logic [7:0] res;
      bit         found;
      res = REPLACEMENT;
      found = 1'b0;
      if (cp >= 11'h410 && cp <= 11'h44F) begin
         res = 8'(cp - 11'h350);
      end else if (cp >= 11'h080 && cp <= 11'h0FF) begin
         res = cp[7:0];
      end else if (cp >= 11'h402 && cp <= 11'h403) begin
         res = 8'(cp - 11'h382);
      end else begin
         for (int k = 0; k < 62; k++) begin
            if (!found && CP1251_HIGH_CP[k] == {5'd0, cp}) begin
               res = 8'h82 + 8'(k);
               found = 1'b1;
            end
         end
      end
      return res;
   endfunction

   function automatic void decode_utf8_byte(input logic [7:0] b);
      if (dec_mode != MODE_DISCARD) begin
         decoded_count++;
      end
      case (dec_mode)
         MODE_IDLE: begin
            if (b == 8'h00) begin
               cp1251_pending.push_back({8'h00, ST_END});
            end else if (!b[7]) begin
               cp1251_pending.push_back({b, ST_CHAR});
            end else if (b[7:5] == 3'b110) begin
               dec_lead = b[4:0];
               dec_mode = MODE_SECOND;
            end else if (b[7:4] == 4'b1110) begin
               dec_skip = 2'd2;
               dec_mode = MODE_SKIP;
            end else if (b[7:3] == 5'b11110) begin
               dec_skip = 2'd3;
               dec_mode = MODE_SKIP;
            end else begin
               dec_mode = MODE_DISCARD;
               cp1251_pending.push_back({8'h00, ST_BAD});
            end
         end
         MODE_SECOND: begin
            dec_mode = MODE_IDLE;
            if (b == 8'h00) begin
               cp1251_pending.push_back({8'h00, ST_BAD});
            end else begin
               // use the low six bits even when the top bits are not 10
               cp1251_pending.push_back({to_cp1251({dec_lead, b[5:0]}), ST_CHAR});
            end
         end
         MODE_SKIP: begin
            if (b == 8'h00) begin
               dec_mode = MODE_IDLE;
               dec_skip = 2'd0;
               cp1251_pending.push_back({8'h00, ST_BAD});
            end else begin
               dec_skip = dec_skip - 2'd1;
               if (dec_skip == 2'd0) begin
                  dec_mode = MODE_IDLE;
                  cp1251_pending.push_back({REPLACEMENT, ST_CHAR});
               end
            end
         end
         default: begin
            if (b == 8'h00) begin
               dec_mode = MODE_IDLE;
            end
         end
      endcase
   endfunction

   // predict on every accepted byte, then check every accepted result
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            decode_utf8_byte(req_ch.in_byte);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (cp1251_pending.size() == 0) begin
               $error("unexpected transaction: out_byte %h status %0d",
                      rsp_ch.out_byte, rsp_ch.status);
               fail_count++;
            end else begin
               cp1251_head = cp1251_pending.pop_front();
               if (rsp_ch.out_byte !== cp1251_head.out_byte) begin
                  $error("out_byte: expected %h, actual %h",
                         cp1251_head.out_byte, rsp_ch.out_byte);
                  fail_count++;
               end
               if (rsp_ch.status !== cp1251_head.status) begin
                  $error("status: expected %0d, actual %0d",
                         cp1251_head.status, rsp_ch.status);
                  fail_count++;
               end
            end
         end
      end
   end

   // result side: stall a random number of cycles before each transaction
   initial begin
      rsp_ch.ready = 1'b0;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
         recv_stall = recv_burst ? 0 : $urandom_range(0, 19);
         @(negedge clock);
         if (recv_stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (recv_stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.in_byte = b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic test_ascii_and_end();
      send_byte(8'h7F);
      send_byte(8'h00);
   endtask

   task automatic test_two_byte_mapping();
      logic [7:0] seq [12];
      // Cyrillic ends, a low special, a table hit, an overlong form,
      // and a second byte that is not a continuation
      seq = '{8'hD0, 8'h90, 8'hD1, 8'h8F, 8'hD0, 8'h82,
              8'hD1, 8'h93, 8'hC1, 8'h81, 8'hD0, 8'hD0};
      for (int i = 0; i < 12; i++) send_byte(seq[i]);
   endtask

   task automatic test_long_sequences();
      logic [7:0] seq [7];
      seq = '{8'hE2, 8'h80, 8'h9A, 8'hF0, 8'h9F, 8'h98, 8'h80};
      for (int i = 0; i < 7; i++) send_byte(seq[i]);
   endtask

   task automatic test_malformed_strings();
      logic [7:0] seq [5];
      // zero inside a sequence, then a bad lead whose string gets discarded
      seq = '{8'hC3, 8'h00, 8'hFF, 8'h41, 8'h00};
      for (int i = 0; i < 5; i++) send_byte(seq[i]);
   endtask

   task automatic test_random_strings(input int target);
      int unsigned start_count;
      int          len;
      int          pick;
      int          break_at;
      bit          broken;
      logic [10:0] cp;
      logic [7:0]  cont;
      start_count = decoded_count;
      while (decoded_count - start_count < target) begin
         if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 8);
            repeat (len) send_byte(8'($urandom_range(0, 255)));
         end else begin
            len = $urandom_range(0, 10);
            broken = ($urandom_range(0, 5) == 0);
            break_at = $urandom_range(0, len);
            for (int c = 0; c <= len; c++) begin
               if (broken && c == break_at) begin
                  case ($urandom_range(0, 2))
                     0: begin
                        // truncate a sequence with the end of string
                        send_byte(8'($urandom_range(8'hC0, 8'hF7)));
                        send_byte(8'h00);
                     end
                     1: begin
                        if ($urandom_range(0, 1) == 1) begin
                           send_byte(8'($urandom_range(8'h80, 8'hBF)));
                        end else begin
                           send_byte(8'($urandom_range(8'hF8, 8'hFF)));
                        end
                        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(1, 255)));
                     end
                     default: send_byte(8'($urandom_range(0, 255)));
                  endcase
               end
               if (c < len) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 30) begin
                     send_byte(8'($urandom_range(1, 127)));
                  end else if (pick < 70) begin
                     case ($urandom_range(0, 4))
                        0: cp = 11'h410 + 11'($urandom_range(0, 63));
                        1: cp = 11'($urandom_range(11'h080, 11'h0FF));
                        2: cp = 11'h402 + 11'($urandom_range(0, 1));
                        3: cp = CP1251_HIGH_CP[$urandom_range(0, 61)][10:0];
                        default: cp = 11'($urandom_range(0, 11'h7FF));
                     endcase
                     cont = {2'b10, cp[5:0]};
                     if ($urandom_range(0, 15) == 0) cont[7:6] = 2'($urandom_range(0, 3));
                     send_byte({3'b110, cp[10:6]});
                     send_byte(cont);
                  end else begin
                     if (pick < 85) begin
                        send_byte({4'b1110, 4'($urandom_range(0, 15))});
                        repeat (2) begin
                           if ($urandom_range(0, 7) == 0) begin
                              send_byte(8'($urandom_range(1, 255)));
                           end else begin
                              send_byte({2'b10, 6'($urandom_range(0, 63))});
                           end
                        end
                     end else begin
                        send_byte({5'b11110, 3'($urandom_range(0, 7))});
                        repeat (3) begin
                           if ($urandom_range(0, 7) == 0) begin
                              send_byte(8'($urandom_range(1, 255)));
                           end else begin
                              send_byte({2'b10, 6'($urandom_range(0, 63))});
                           end
                        end
                     end
                  end
               end
            end
         end
         send_byte(8'h00);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.in_byte = 8'h00;
      dec_mode = MODE_IDLE;
      dec_lead = 5'd0;
      dec_skip = 2'd0;
      decoded_count = 0;
      cycle_count = 0;
      fail_count = 0;
      send_burst = 1'b0;
      recv_burst = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_ascii_and_end();
      test_two_byte_mapping();
      test_long_sequences();
      test_malformed_strings();
      test_random_strings(RANDOM_BYTES);

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (cp1251_pending.size() != 0) @(posedge clock);
      // let any stray result surface
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/u2c_pkg.sv
sv/u2c_if.sv
sv/utf8_to_cp1251_stream_core.sv
sv/u2c_checker.sv
tb/tb_utf8_to_cp1251_stream_core.sv
